@@ rtl/mmm_pkg.sv @@
// Shared types, field widths and codes of the matrix multiply unit.
package mmm_pkg;

    localparam int DIM_DEFAULT = 8;
    localparam int MODE_W = 2;
    localparam int ROW_W = 3;
    localparam int COL_W = 3;
    localparam int VAL_W = 32;
    localparam int FRAC_W = 16;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]        out_row;
        logic [COL_W-1:0]        out_col;
        logic signed [VAL_W-1:0] product;
        logic                    last;
    } t_out_item;

    // One multiply-accumulate step handed to the shared unit.
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             lst;
        logic             fin;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_mac_op;

    // A finished element leaving the shared unit.
    typedef struct packed {
        logic      vld;
        t_out_item item;
    } t_mac_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

@@ rtl/mmm_if.sv @@
// Valid/ready stream interfaces for the input and result channels.
interface mmm_in_if;
    import mmm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmm_out_if;
    import mmm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mmm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mmm_mac.sv @@
// Shared multiply-accumulate unit with shift and saturation of each finished sum.
module mmm_mac #(
    parameter int DIM = mmm_pkg::DIM_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  mmm_pkg::t_mac_op                 i_op,
    input  logic signed [mmm_pkg::VAL_W-1:0] i_a,
    input  logic signed [mmm_pkg::VAL_W-1:0] i_b,
    output mmm_pkg::t_mac_res                o_res,
    output logic                             o_busy
);
    import mmm_pkg::*;

    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W = PROD_W + $clog2(DIM) + 1;
    localparam int TOP_LO = FRAC_W + VAL_W - 1;

    t_mac_op                  r_op;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_sum;
    logic [ACC_W-TOP_LO-1:0]  w_hi;
    logic                     w_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else if (i_adv) begin
            r_op <= i_op;
        end
    end

    // The product is registered before it reaches the adder.
    always_ff @(posedge i_clk) begin
        if (i_adv && i_op.vld) begin
            r_prod <= i_a * i_b;
        end
        if (i_adv && r_op.vld) begin
            r_acc <= w_sum;
        end
    end

    assign w_sum = (r_op.first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);

    // The shifted sum fits in 32 bits when every bit from TOP_LO up agrees.
    assign w_hi = w_sum[ACC_W-1:TOP_LO];
    assign w_fits = (&w_hi) || !(|w_hi);

    always_comb begin
        o_res.vld = r_op.vld && r_op.lst;
        o_res.item.out_row = r_op.row;
        o_res.item.out_col = r_op.col;
        o_res.item.last = r_op.fin;
        if (w_fits) begin
            o_res.item.product = w_sum[TOP_LO:FRAC_W];
        end else if (w_sum[ACC_W-1]) begin
            o_res.item.product = SAT_MIN;
        end else begin
            o_res.item.product = SAT_MAX;
        end
    end

    assign o_busy = r_op.vld;
endmodule

@@ rtl/matrix_matrix_multiply_unit.sv @@
// Top level of the matrix multiply unit: storage, sequencer and result register.
// A load beat is written into its store while the unit is idle, and the unit stays ready.
// A compute beat runs DIM*DIM dot products of DIM steps each on one shared MAC, and the
// unit accepts no new beat until the last step has left the MAC and it is idle again.
// With the sink always ready one result element leaves per finished dot product.
// Reset clears the sequencer and the valid flags; the matrix stores keep their contents.
module matrix_matrix_multiply_unit #(
    parameter int DIM = mmm_pkg::DIM_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mmm_in_if.sink           i_in,
    mmm_out_if.source        o_out
);
    import mmm_pkg::*;

    // Rows and columns are packed side by side into the RAM address.
    localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH = 2 ** ADDR_W;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic [IDX_W-1:0] r_k;
    t_mac_op          r_s1;
    t_mac_op          w_op;
    t_mac_res         w_res;
    logic             w_mac_busy;
    logic             r_out_vld;
    t_out_item        r_out;

    logic              w_accept;
    logic              w_in_range;
    logic              w_adv;
    logic              w_issue;
    logic              w_final_issue;
    logic              w_ready;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr_a;
    logic [ADDR_W-1:0] w_raddr_b;
    logic [VAL_W-1:0]  w_a;
    logic [VAL_W-1:0]  w_b;

    assign w_accept = i_in.valid && w_ready;
    assign w_in_range = (int'(i_in.data.row) < DIM) && (int'(i_in.data.col) < DIM);
    assign w_waddr = {i_in.data.row[IDX_W-1:0], i_in.data.col[IDX_W-1:0]};

    // The whole compute pipeline moves only when the result register can take a beat.
    assign w_adv = !r_out_vld || o_out.ready;
    assign w_final_issue = w_issue && (r_k == IDX_MAX) && (r_col == IDX_MAX)
                           && (r_row == IDX_MAX);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in.data.mode == MODE_COMPUTE) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_final_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The final element may still sit in the result register.
                if (!r_s1.vld && !w_mac_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State-dependent outputs.
    always_comb begin
        w_ready = 1'b0;
        w_issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
            end
            ST_RUN: begin
                w_issue = w_adv;
            end
            ST_DRAIN: begin
                w_issue = 1'b0;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The k counter runs fastest, then the column, then the row, so that the
    // results come out in row-major order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_k <= '0;
        end else if (w_accept && i_in.data.mode == MODE_COMPUTE) begin
            r_row <= '0;
            r_col <= '0;
            r_k <= '0;
        end else if (w_issue) begin
            if (r_k == IDX_MAX) begin
                r_k <= '0;
                if (r_col == IDX_MAX) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_comb begin
        w_op.vld = w_issue;
        w_op.first = (r_k == '0);
        w_op.lst = (r_k == IDX_MAX);
        w_op.fin = (r_row == IDX_MAX) && (r_col == IDX_MAX);
        w_op.row = ROW_W'(r_row);
        w_op.col = COL_W'(r_col);
    end

    assign w_raddr_a = {r_row, r_k};
    assign w_raddr_b = {r_k, r_col};

    // Tags travel beside the RAM read so they line up with its registered data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_adv) begin
            r_s1 <= w_op;
        end
    end

    mmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in.data.mode == MODE_LOAD_A && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_in.data.value),
        .i_re    (w_issue),
        .i_raddr (w_raddr_a),
        .o_rdata (w_a)
    );

    mmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in.data.mode == MODE_LOAD_B && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_in.data.value),
        .i_re    (w_issue),
        .i_raddr (w_raddr_b),
        .o_rdata (w_b)
    );

    mmm_mac #(
        .DIM (DIM)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_op    (r_s1),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_res   (w_res),
        .o_busy  (w_mac_busy)
    );

    // Result register: it loads whenever it is empty or its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.vld) begin
            r_out <= w_res.item;
        end
    end

    assign i_in.ready = w_ready;
    assign o_out.valid = r_out_vld;
    assign o_out.data = r_out;

    // The pipeline is empty whenever new beats are accepted.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_s1.vld && !w_mac_busy)
        else $error("pipeline busy while idle");

    // A compute beat starts the sequencer at the first element.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.data.mode == MODE_COMPUTE |=>
        r_state == ST_RUN && r_row == '0 && r_col == '0 && r_k == '0)
        else $error("compute did not start cleanly");

    // The last flag marks the bottom-right element only.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.last |->
        r_out.out_row == ROW_W'(DIM - 1) && r_out.out_col == COL_W'(DIM - 1))
        else $error("last flag on a wrong element");

    // A finished element never overwrites a beat that was not taken.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_out))
        else $error("result register overwritten");

    // Result coordinates stay inside the matrix.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> int'(r_out.out_row) < DIM && int'(r_out.out_col) < DIM)
        else $error("result coordinate out of range");
endmodule

@@ tb/mmm_checker.sv @@
// Scoreboard for the matrix multiply unit: tracks both stores, predicts C and checks results.
`timescale 1ns / 100ps
module mmm_checker #(
    parameter int DIM = mmm_pkg::DIM_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mmm_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mmm_pkg::t_out_item i_out_data,
    output int                 o_mismatches,
    output int                 o_outstanding,
    output int                 o_checked
);
    import mmm_pkg::*;

    // Entries are addressed row * 8 + col whatever DIM is.
    localparam int STRIDE = 2 ** COL_W;
    localparam int ENTRIES = 2 ** (ROW_W + COL_W);

    logic signed [VAL_W-1:0] a_store [0:ENTRIES-1];
    logic signed [VAL_W-1:0] b_store [0:ENTRIES-1];
    t_out_item               c_elements_due [$];
    int                      mismatch_count = 0;
    int                      checked_count = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = c_elements_due.size();
    assign o_checked     = checked_count;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            a_store[i] = '0;
            b_store[i] = '0;
        end
    end

    // One element of C: exact dot product, arithmetic shift by the fraction width,
    // then clamp to the signed 32-bit range.
    function automatic logic signed [VAL_W-1:0] c_element(input int r, input int c);
        logic signed [71:0] dot_sum;
        logic signed [63:0] term;
        logic signed [71:0] scaled;
        dot_sum = '0;
        for (int k = 0; k < DIM; k++) begin
            term    = a_store[r * STRIDE + k] * b_store[k * STRIDE + c];
            dot_sum = dot_sum + term;
        end
        scaled = dot_sum >>> FRAC_W;
        if (scaled > 72'sh7FFF_FFFF)
            return SAT_MAX;
        if (scaled < -72'sh8000_0000)
            return SAT_MIN;
        return scaled[VAL_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item elem;
        if (i_rst_n) begin
            // Input side first, so a prediction is in place before any result it causes.
            if (i_in_valid && i_in_ready) begin
                if ((i_in_data.mode == MODE_LOAD_A || i_in_data.mode == MODE_LOAD_B) &&
                    i_in_data.row < DIM && i_in_data.col < DIM) begin
                    if (i_in_data.mode == MODE_LOAD_A)
                        a_store[i_in_data.row * STRIDE + i_in_data.col] = i_in_data.value;
                    else
                        b_store[i_in_data.row * STRIDE + i_in_data.col] = i_in_data.value;
                end else if (i_in_data.mode == MODE_COMPUTE) begin
                    for (int r = 0; r < DIM; r++) begin
                        for (int c = 0; c < DIM; c++) begin
                            elem.out_row = r[ROW_W-1:0];
                            elem.out_col = c[COL_W-1:0];
                            elem.product = c_element(r, c);
                            elem.last    = (r == DIM - 1) && (c == DIM - 1);
                            c_elements_due.push_back(elem);
                        end
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (c_elements_due.size() == 0) begin
                    report_mismatch("unexpected result beat", i_out_data.product, '0);
                end else begin
                    want = c_elements_due.pop_front();
                    checked_count++;
                    if (i_out_data.out_row !== want.out_row)
                        report_mismatch("out_row", i_out_data.out_row, want.out_row);
                    if (i_out_data.out_col !== want.out_col)
                        report_mismatch("out_col", i_out_data.out_col, want.out_col);
                    if (i_out_data.product !== want.product)
                        report_mismatch("product", i_out_data.product, want.product);
                    if (i_out_data.last !== want.last)
                        report_mismatch("last", i_out_data.last, want.last);
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the matrix multiply unit: clock, reset, beat stimulus and the verdict.
`timescale 1ns / 100ps
module tb;
    import mmm_pkg::*;

    localparam int DIM = DIM_DEFAULT;
    // Mode code the unit has to ignore.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Random beats that the unit acts on; ignored beats come on top of these.
    localparam int RANDOM_BEATS = 40;
    // Well above the slowest legal run: even if every random beat were a compute of
    // 64 elements, each element held up by a full receiver stall, plus every sender gap.
    localparam int CYCLE_LIMIT = 400000;
    // After the last element, room for anything stray to show up on the result channel.
    localparam int SETTLE_CYCLES = 4 * DIM + 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mmm_in_if  in_ch ();
    mmm_out_if out_ch ();

    // Once set, neither side inserts idle cycles any more.
    bit quiet = 1'b0;
    int cycle_count = 0;
    int beats_sent = 0;
    int computes_sent = 0;
    int mismatches;
    int outstanding;
    int checked;

    always #6 i_clk = ~i_clk;

    matrix_matrix_multiply_unit #(
        .DIM(DIM)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    mmm_checker #(
        .DIM(DIM)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding),
        .o_checked    (checked)
    );

    // A hung unit or a lost result would otherwise keep the run going forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d elements still due", cycle_count,
                     outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Element values: mostly small numbers between -8 and 8, some full-range words that
    // toggle every bit, the extremes, and mid-sized values whose sums saturate.
    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            5, 6, 7:       return $urandom;
            8: begin
                case ($urandom_range(0, 3))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:       return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic t_in_item make_beat(input logic [MODE_W-1:0] mode, input int r,
                                           input int c, input logic signed [VAL_W-1:0] v);
        t_in_item beat;
        beat.mode  = mode;
        beat.row   = r[ROW_W-1:0];
        beat.col   = c[COL_W-1:0];
        beat.value = v;
        return beat;
    endfunction

    // Presents one beat and returns at the edge where it is taken. Valid stays high
    // from one beat to the next unless an idle burst is inserted in between, so each
    // step sees at most one assignment to it.
    task automatic send_beat(input t_in_item beat);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        beats_sent++;
        if (beat.mode == MODE_COMPUTE)
            computes_sent++;
    endtask

    // Result side: ready alternates between open stretches and stall bursts, so
    // stalls land at every point of a compute, including on the marked last element.
    initial begin
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_in_item beat;
        int       pick;
        int       acted;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every entry of both stores is written before the first compute, since the
        // stores come out of reset undefined. The fill is shaped so that the first
        // compute already hits the corners of the arithmetic: row 0 of A and column 0
        // of B at the positive extreme give positive saturation, rows 1 and DIM-1 of A
        // at the negative extreme give negative saturation against column 0, and the
        // negative extremes of row DIM-1 and column DIM-1 meet in a sum that no
        // longer fits in 64 bits.
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                send_beat(make_beat(MODE_LOAD_A, r, c,
                                    (r == 0) ? SAT_MAX :
                                    (r == 1 || r == DIM - 1) ? SAT_MIN : random_value()));
                send_beat(make_beat(MODE_LOAD_B, r, c,
                                    (c == 0) ? SAT_MAX :
                                    (c == DIM - 1) ? SAT_MIN : random_value()));
            end
        end

        // Directed beats. Row, column and value of a compute are don't-cares, so the
        // two computes carry opposite patterns there; the unused mode is sent with
        // both all-zero and all-one fields.
        send_beat(make_beat(MODE_COMPUTE, 0, 0, '0));
        send_beat(make_beat(MODE_UNUSED, DIM - 1, DIM - 1, '1));
        send_beat(make_beat(MODE_LOAD_A, 0, 0, 32'sh0001_0000));
        send_beat(make_beat(MODE_LOAD_B, 0, 0, '1));
        send_beat(make_beat(MODE_LOAD_A, DIM - 1, DIM - 1, '0));
        send_beat(make_beat(MODE_LOAD_B, DIM - 1, 0, SAT_MIN));
        send_beat(make_beat(MODE_LOAD_A, 1, 0, SAT_MAX));
        send_beat(make_beat(MODE_LOAD_B, 0, DIM - 1, SAT_MAX));
        send_beat(make_beat(MODE_UNUSED, 0, 0, '0));
        send_beat(make_beat(MODE_COMPUTE, DIM - 1, DIM - 1, '1));

        // Random part: mostly loads that keep reshaping both matrices, computes now
        // and then to read them back, and a few beats of the unused mode as noise.
        // The last fifth runs with no idling on either side.
        acted = 0;
        while (acted < RANDOM_BEATS) begin
            if (acted == RANDOM_BEATS * 4 / 5)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            beat = make_beat(MODE_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 7),
                             random_value());
            if (pick < 7)
                beat.mode = MODE_COMPUTE;
            else if (pick < 11)
                beat.mode = MODE_UNUSED;
            else if (pick >= 55)
                beat.mode = MODE_LOAD_B;
            if (beat.mode != MODE_UNUSED)
                acted++;
            send_beat(beat);
        end
        // A closing compute reads back the last loads.
        send_beat(make_beat(MODE_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                            random_value()));
        in_ch.valid <= 1'b0;

        // Step past the acceptance edge first, so the checker has queued the closing compute's elements.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run summary: %0d input beats sent, %0d of them computes, %0d %s",
                 beats_sent, computes_sent, checked, "result elements checked.");
        $display("Covered saturation both ways, sums past 64 bits, ignored modes %s",
                 "and stalls on both channels.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
